// ----- src/trc_pkg.sv -----
// shared types, constants and helper functions of the triangle rectangle clipper
`timescale 1ns / 1ps
package trc_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int QUO_W   = DIFF_W;
  localparam int DVD_W   = 2 * COORD_W;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } cfg_reg_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_SOME  = 2'd1,
    ST_ALL   = 2'd2,
    ST_DEGEN = 2'd3
  } status_t;

  // one token of the vertex stream between cells: a vertex or the polygon end
  typedef struct packed {
    logic   is_end;
    logic   clipped;
    coord_t x;
    coord_t y;
  } vtx_tok_t;

  // the original triangle corners
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } corners_t;

  // sign-extended difference of two coordinates
  function automatic logic signed [DIFF_W-1:0] sdiff(input coord_t a, input coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // magnitude of a coordinate difference
  function automatic logic [DIFF_W-1:0] smag(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

endpackage

// ----- src/trc_clip_cell.sv -----
// one clip plane cell: buffers a polygon, clips it against one edge, streams it on
`timescale 1ns / 1ps
module trc_clip_cell #(
  parameter int MAX_VERTICES = 7,
  parameter int AXIS = 0,
  parameter int KEEP_GT = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  trc_pkg::coord_t   edge_pos,
  input  logic              in_valid,
  output logic              in_ready,
  input  trc_pkg::vtx_tok_t in_tok,
  output logic              out_valid,
  input  logic              out_ready,
  output trc_pkg::vtx_tok_t out_tok
);
  import trc_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int STEP_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  typedef enum logic [6:0] {
    C_RECV = 7'b0000001,
    C_EVAL = 7'b0000010,
    C_MUL  = 7'b0000100,
    C_DIV  = 7'b0001000,
    C_XOUT = 7'b0010000,
    C_VOUT = 7'b0100000,
    C_END  = 7'b1000000
  } cstate_t;

  cstate_t            state;
  coord_t             vbuf_x [MAX_VERTICES];
  coord_t             vbuf_y [MAX_VERTICES];
  logic [CNT_W-1:0]   n_in;
  logic [CNT_W-1:0]   nout;
  logic [IDX_W-1:0]   cur_idx;
  coord_t             prev_x;
  coord_t             prev_y;
  logic               clipped;
  logic [DIFF_W-1:0]  mag_d;
  logic [DIFF_W-1:0]  mag_num;
  logic [DIFF_W-1:0]  md;
  logic               negoff;
  logic               zero_off;
  logic [QUO_W-1:0]   rem;
  logic [QUO_W-1:0]   quo;
  logic [QUO_W-1:0]   div_lo;
  logic [STEP_W-1:0]  div_step;

  coord_t                   cur_x, cur_y, cur_a, cur_o, prev_a, prev_o, other;
  logic                     pin, cin, room, slot_free, emit;
  vtx_tok_t                 emit_tok;
  logic signed [DIFF_W-1:0] den_s, num_s, d_s;
  logic [PROD_W-1:0]        dividend;
  logic [QUO_W:0]           rem_sh;
  logic [QUO_W:0]           other_w;

  // current and previous vertex, split along the clip axis
  assign cur_x  = vbuf_x[cur_idx];
  assign cur_y  = vbuf_y[cur_idx];
  assign cur_a  = (AXIS == 0) ? cur_x : cur_y;
  assign cur_o  = (AXIS == 0) ? cur_y : cur_x;
  assign prev_a = (AXIS == 0) ? prev_x : prev_y;
  assign prev_o = (AXIS == 0) ? prev_y : prev_x;

  // inside tests, a point on the edge counts as inside
  assign pin = (KEEP_GT != 0) ? (prev_a >= edge_pos) : (prev_a <= edge_pos);
  assign cin = (KEEP_GT != 0) ? (cur_a >= edge_pos) : (cur_a <= edge_pos);

  assign den_s = sdiff(cur_a, prev_a);
  assign num_s = sdiff(edge_pos, prev_a);
  assign d_s   = sdiff(cur_o, prev_o);

  // rounded offset: (|d| * |num| + |den| / 2) / |den|
  assign dividend = mag_d * mag_num + PROD_W'(md >> 1);
  assign rem_sh   = {rem, div_lo[QUO_W-1]};

  // crossing coordinate along the edge
  assign other_w = negoff ? ((QUO_W+1)'(prev_o) - {1'b0, quo})
                          : ((QUO_W+1)'(prev_o) + {1'b0, quo});
  assign other   = zero_off ? prev_o : coord_t'(other_w[COORD_W-1:0]);

  assign room      = (nout < CNT_MAX);
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == C_RECV);

  // token leaving the cell
  always_comb begin
    emit     = 1'b0;
    emit_tok = '0;
    unique case (state)
      C_XOUT: begin
        if (slot_free && room) begin
          emit       = 1'b1;
          emit_tok.x = (AXIS == 0) ? edge_pos : other;
          emit_tok.y = (AXIS == 0) ? other : edge_pos;
        end
      end
      C_VOUT: begin
        if (slot_free && cin && room) begin
          emit       = 1'b1;
          emit_tok.x = cur_x;
          emit_tok.y = cur_y;
        end
      end
      C_END: begin
        if (slot_free) begin
          emit             = 1'b1;
          emit_tok.is_end  = 1'b1;
          emit_tok.clipped = clipped;
        end
      end
      default: ;
    endcase
  end

  // cell sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_RECV;
      n_in    <= '0;
      nout    <= '0;
      clipped <= 1'b0;
      cur_idx <= '0;
    end else begin
      unique case (state)
        C_RECV: begin
          if (in_valid) begin
            if (in_tok.is_end) begin
              clipped <= clipped | in_tok.clipped;
              cur_idx <= '0;
              state   <= (n_in == '0) ? C_END : C_EVAL;
            end else begin
              vbuf_x[n_in[IDX_W-1:0]] <= in_tok.x;
              vbuf_y[n_in[IDX_W-1:0]] <= in_tok.y;
              prev_x <= in_tok.x;
              prev_y <= in_tok.y;
              n_in   <= n_in + CNT_W'(1);
            end
          end
        end
        C_EVAL: begin
          if (pin != cin) begin
            mag_d    <= smag(d_s);
            mag_num  <= smag(num_s);
            md       <= smag(den_s);
            negoff   <= (d_s[DIFF_W-1] != num_s[DIFF_W-1]) != den_s[DIFF_W-1];
            zero_off <= (d_s == '0) || (num_s == '0);
            state    <= C_MUL;
          end else begin
            state <= C_VOUT;
          end
        end
        C_MUL: begin
          rem      <= QUO_W'(dividend[DVD_W-1:QUO_W]);
          div_lo   <= dividend[QUO_W-1:0];
          quo      <= '0;
          div_step <= '0;
          state    <= C_DIV;
        end
        C_DIV: begin
          if (rem_sh >= {1'b0, md}) begin
            rem <= QUO_W'(rem_sh - {1'b0, md});
            quo <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[QUO_W-1:0];
            quo <= {quo[QUO_W-2:0], 1'b0};
          end
          div_lo   <= {div_lo[QUO_W-2:0], 1'b0};
          div_step <= div_step + STEP_W'(1);
          if (div_step == STEP_W'(QUO_W - 1)) begin
            state <= C_XOUT;
          end
        end
        C_XOUT: begin
          if (slot_free) begin
            if (room) begin
              nout <= nout + CNT_W'(1);
            end
            clipped <= 1'b1;
            state   <= C_VOUT;
          end
        end
        C_VOUT: begin
          if (!(cin && room) || slot_free) begin
            if (cin && room) begin
              nout <= nout + CNT_W'(1);
            end
            prev_x <= cur_x;
            prev_y <= cur_y;
            if (CNT_W'(cur_idx) + CNT_W'(1) == n_in) begin
              state <= C_END;
            end else begin
              cur_idx <= cur_idx + IDX_W'(1);
              state   <= C_EVAL;
            end
          end
        end
        C_END: begin
          if (slot_free) begin
            n_in    <= '0;
            nout    <= '0;
            clipped <= 1'b0;
            state   <= C_RECV;
          end
        end
        default: state <= C_RECV;
      endcase
    end
  end

  // output stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tok <= emit_tok;
    end
  end

endmodule

// ----- src/trc_weight_unit.sv -----
// collects the clipped polygon and computes barycentric weights of each vertex
`timescale 1ns / 1ps
module trc_weight_unit #(
  parameter int MAX_VERTICES = 7,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  trc_pkg::corners_t      corners,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  trc_pkg::vtx_tok_t      in_tok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output trc_pkg::coord_t        out_x,
  output trc_pkg::coord_t        out_y,
  output logic [FRACTION_BITS:0] weight_first,
  output logic [FRACTION_BITS:0] weight_second,
  output logic [1:0]             clip_status,
  output logic [2:0]             vertex_count,
  output logic                   has_vertex,
  output logic                   is_last
);
  import trc_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int W_W   = FRACTION_BITS + 1;
  localparam int IT_W  = $clog2(FRACTION_BITS);
  localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(1) << FRACTION_BITS;

  typedef enum logic [15:0] {
    W_RECV  = 16'b0000000000000001,
    W_PREP  = 16'b0000000000000010,
    W_DM0   = 16'b0000000000000100,
    W_DM1   = 16'b0000000000001000,
    W_DSUM  = 16'b0000000000010000,
    W_VLOAD = 16'b0000000000100000,
    W_M0    = 16'b0000000001000000,
    W_M1    = 16'b0000000010000000,
    W_M2    = 16'b0000000100000000,
    W_M3    = 16'b0000001000000000,
    W_M4    = 16'b0000010000000000,
    W_WSET  = 16'b0000100000000000,
    W_WITER = 16'b0001000000000000,
    W_WRND  = 16'b0010000000000000,
    W_OUT   = 16'b0100000000000000,
    W_EMPTY = 16'b1000000000000000
  } wstate_t;

  wstate_t                  state;
  coord_t                   vx [MAX_VERTICES];
  coord_t                   vy [MAX_VERTICES];
  logic [CNT_W-1:0]         n;
  logic [IDX_W-1:0]         k;
  logic                     clipped;
  logic signed [DIFF_W-1:0] da, db, dc, de, df, ppx, ppy;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, acc, mul_p;
  logic signed [ACC_W-1:0]  den, num0, num1;
  logic signed [ACC_W-1:0]  sum_w, num_sel, num_adj, den_adj;
  logic [ACC_W-1:0]         rem, dd, rem_sh;
  logic [W_W-1:0]           q, wa, wb, w_val;
  logic [IT_W-1:0]          it;
  logic                     wsel, early, w_done, degen, last_k, slot_free, emit;

  assign in_ready  = (state == W_RECV);
  assign slot_free = !out_valid || out_ready;
  assign degen     = (den == '0);
  assign last_k    = (CNT_W'(k) + CNT_W'(1) == n);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      W_DM0: begin mul_a = da; mul_b = de; end
      W_DM1: begin mul_a = db; mul_b = df; end
      W_M0:  begin mul_a = da; mul_b = ppx; end
      W_M1:  begin mul_a = db; mul_b = ppy; end
      W_M2:  begin mul_a = dc; mul_b = ppx; end
      W_M3:  begin mul_a = de; mul_b = ppy; end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign sum_w = ACC_W'(acc) + ACC_W'(prod);

  // weight setup: fold the sign of the area into the numerator
  assign num_sel = wsel ? num1 : num0;
  assign num_adj = den[ACC_W-1] ? -num_sel : num_sel;
  assign den_adj = den[ACC_W-1] ? -den : den;
  assign early   = (num_adj <= 0) || (num_adj >= den_adj);
  assign rem_sh  = {rem[ACC_W-2:0], 1'b0};

  // finished weight value
  always_comb begin
    w_done = 1'b0;
    w_val  = '0;
    if (state == W_WSET && early) begin
      w_done = 1'b1;
      w_val  = (num_adj <= 0) ? '0 : WEIGHT_ONE;
    end else if (state == W_WRND) begin
      w_done = 1'b1;
      w_val  = q + W_W'(rem_sh >= dd);
    end
  end

  assign emit = slot_free && ((state == W_OUT) || (state == W_EMPTY));

  // sequencer
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (rst) begin
      state   <= W_RECV;
      n       <= '0;
      k       <= '0;
      clipped <= 1'b0;
      wsel    <= 1'b0;
    end else begin
      unique case (state)
        W_RECV: begin
          if (in_valid) begin
            if (in_tok.is_end) begin
              clipped <= in_tok.clipped;
              k       <= '0;
              state   <= (n == '0) ? W_EMPTY : W_PREP;
            end else begin
              vx[n[IDX_W-1:0]] <= in_tok.x;
              vy[n[IDX_W-1:0]] <= in_tok.y;
              n <= n + CNT_W'(1);
            end
          end
        end
        W_PREP: begin
          da    <= sdiff(corners.y1, corners.y2);
          db    <= sdiff(corners.x2, corners.x1);
          dc    <= sdiff(corners.y2, corners.y0);
          de    <= sdiff(corners.x0, corners.x2);
          df    <= sdiff(corners.y0, corners.y2);
          state <= W_DM0;
        end
        W_DM0: state <= W_DM1;
        W_DM1: begin
          acc   <= prod;
          state <= W_DSUM;
        end
        W_DSUM: begin
          den   <= sum_w;
          state <= W_VLOAD;
        end
        W_VLOAD: begin
          ppx <= sdiff(vx[k], corners.x2);
          ppy <= sdiff(vy[k], corners.y2);
          if (degen) begin
            wa    <= '0;
            wb    <= '0;
            state <= W_OUT;
          end else begin
            wsel  <= 1'b0;
            state <= W_M0;
          end
        end
        W_M0: state <= W_M1;
        W_M1: begin
          acc   <= prod;
          state <= W_M2;
        end
        W_M2: begin
          num0  <= sum_w;
          state <= W_M3;
        end
        W_M3: begin
          acc   <= prod;
          state <= W_M4;
        end
        W_M4: begin
          num1  <= sum_w;
          state <= W_WSET;
        end
        W_WSET: begin
          if (early) begin
            state <= wsel ? W_OUT : W_WSET;
          end else begin
            rem   <= num_adj;
            dd    <= den_adj;
            q     <= '0;
            it    <= '0;
            state <= W_WITER;
          end
        end
        W_WITER: begin
          if (rem_sh >= dd) begin
            rem <= rem_sh - dd;
            q   <= {q[W_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[W_W-2:0], 1'b0};
          end
          it <= it + IT_W'(1);
          if (it == IT_W'(FRACTION_BITS - 1)) begin
            state <= W_WRND;
          end
        end
        W_WRND: state <= wsel ? W_OUT : W_WSET;
        W_OUT: begin
          if (slot_free) begin
            if (last_k) begin
              n       <= '0;
              k       <= '0;
              clipped <= 1'b0;
              state   <= W_RECV;
            end else begin
              k     <= k + IDX_W'(1);
              state <= W_VLOAD;
            end
          end
        end
        W_EMPTY: begin
          if (slot_free) begin
            clipped <= 1'b0;
            state   <= W_RECV;
          end
        end
        default: state <= W_RECV;
      endcase

      // store a finished weight
      if (w_done) begin
        if (!wsel) begin
          wa   <= w_val;
          wsel <= 1'b1;
        end else begin
          wb <= w_val;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state == W_EMPTY) begin
        out_x         <= '0;
        out_y         <= '0;
        weight_first  <= '0;
        weight_second <= '0;
        clip_status   <= ST_ALL;
        vertex_count  <= '0;
        has_vertex    <= 1'b0;
        is_last       <= 1'b1;
      end else begin
        out_x         <= vx[k];
        out_y         <= vy[k];
        weight_first  <= wa;
        weight_second <= wb;
        clip_status   <= degen ? ST_DEGEN : (clipped ? ST_SOME : ST_NONE);
        vertex_count  <= n[2:0];
        has_vertex    <= 1'b1;
        is_last       <= last_k;
      end
    end
  end

endmodule

// ----- src/triangle_rectangle_clipper.sv -----
// Clips one triangle against an axis-aligned rectangle with four chained clip
// cells (left, right, top, bottom) and emits the resulting polygon vertices with
// barycentric weights. One triangle is in flight at a time: in_ready returns
// after the last result of the previous triangle is taken. Each edge crossing
// runs a 33-step restoring divider inside its clip cell, and each output vertex
// needs four products on the shared 33x33 multiplier (two more for the area,
// once per triangle) plus two bit-serial divisions of FRACTION_BITS steps and a
// rounding step in the weight unit; a weight that saturates skips its division.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
`timescale 1ns / 1ps
module triangle_rectangle_clipper #(
  parameter int MAX_VERTICES = 7,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  trc_pkg::coord_t        first_x,
  input  trc_pkg::coord_t        first_y,
  input  trc_pkg::coord_t        second_x,
  input  trc_pkg::coord_t        second_y,
  input  trc_pkg::coord_t        third_x,
  input  trc_pkg::coord_t        third_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output trc_pkg::coord_t        out_x,
  output trc_pkg::coord_t        out_y,
  output logic [FRACTION_BITS:0] weight_first,
  output logic [FRACTION_BITS:0] weight_second,
  output logic [1:0]             clip_status,
  output logic [2:0]             vertex_count,
  output logic                   has_vertex,
  output logic                   is_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  trc_pkg::coord_t        cfg_data
);
  import trc_pkg::*;

  localparam int NUM_CELLS = 4;
  localparam logic [1:0] FEED_END = 2'd3;
  localparam logic [FRACTION_BITS:0] WEIGHT_ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

  coord_t   clip_left, clip_top, clip_right, clip_bottom;
  corners_t corners;
  logic     busy;
  logic     feeding;
  logic [1:0] feed_cnt;

  vtx_tok_t tok [NUM_CELLS+1];
  logic     tok_valid [NUM_CELLS+1];
  logic     tok_ready [NUM_CELLS+1];
  coord_t   edge_sel [NUM_CELLS];

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;

  // clip rectangle registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_right  <= 32'h7FFF_FFFF;
      clip_bottom <= 32'h7FFF_FFFF;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEFT:   clip_left   <= cfg_data;
        REG_TOP:    clip_top    <= cfg_data;
        REG_RIGHT:  clip_right  <= cfg_data;
        REG_BOTTOM: clip_bottom <= cfg_data;
      endcase
    end
  end

  // request intake and busy tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      feeding  <= 1'b0;
      feed_cnt <= '0;
    end else begin
      if (in_valid && !busy) begin
        busy     <= 1'b1;
        feeding  <= 1'b1;
        feed_cnt <= '0;
      end else if (out_valid && out_ready && is_last) begin
        busy <= 1'b0;
      end
      if (feeding && tok_ready[0]) begin
        if (feed_cnt == FEED_END) begin
          feeding <= 1'b0;
        end else begin
          feed_cnt <= feed_cnt + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !busy) begin
      corners <= '{first_x, first_y, second_x, second_y, third_x, third_y};
    end
  end

  // feed the three corners and an end marker into the first cell
  always_comb begin
    tok[0] = '0;
    unique case (feed_cnt)
      2'd0: begin tok[0].x = corners.x0; tok[0].y = corners.y0; end
      2'd1: begin tok[0].x = corners.x1; tok[0].y = corners.y1; end
      2'd2: begin tok[0].x = corners.x2; tok[0].y = corners.y2; end
      default: tok[0].is_end = 1'b1;
    endcase
  end
  assign tok_valid[0] = feeding;

  assign edge_sel[0] = clip_left;
  assign edge_sel[1] = clip_right;
  assign edge_sel[2] = clip_top;
  assign edge_sel[3] = clip_bottom;

  // chain of clip cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    trc_clip_cell #(
      .MAX_VERTICES(MAX_VERTICES),
      .AXIS        ((i >= 2) ? 1 : 0),
      .KEEP_GT     ((i == 0 || i == 2) ? 1 : 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .edge_pos (edge_sel[i]),
      .in_valid (tok_valid[i]),
      .in_ready (tok_ready[i]),
      .in_tok   (tok[i]),
      .out_valid(tok_valid[i+1]),
      .out_ready(tok_ready[i+1]),
      .out_tok  (tok[i+1])
    );
  end

  trc_weight_unit #(
    .MAX_VERTICES (MAX_VERTICES),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_weight (
    .clk          (clk),
    .rst          (rst),
    .corners      (corners),
    .in_valid     (tok_valid[NUM_CELLS]),
    .in_ready     (tok_ready[NUM_CELLS]),
    .in_tok       (tok[NUM_CELLS]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .weight_first (weight_first),
    .weight_second(weight_second),
    .clip_status  (clip_status),
    .vertex_count (vertex_count),
    .has_vertex   (has_vertex),
    .is_last      (is_last)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a triangle is in flight");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_vertex |-> is_last && clip_status == ST_ALL && vertex_count == 3'd0)
    else $error("empty result not marked all clipped");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_vertex |-> weight_first <= WEIGHT_ONE && weight_second <= WEIGHT_ONE)
    else $error("weight above one");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && clip_status == ST_DEGEN |-> weight_first == '0 && weight_second == '0)
    else $error("degenerate triangle with nonzero weight");
`endif

endmodule

// ----- tb/tb.sv -----
// self-checking testbench of the triangle rectangle clipper
`timescale 1ns / 1ps
module tb;
  import trc_pkg::*;

  localparam int FB       = 16;
  localparam int MAX_VTX  = 7;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint CMAX = 64'sd2147483647;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    coord_t      x;
    coord_t      y;
    logic [FB:0] wf;
    logic [FB:0] ws;
    logic [1:0]  st;
    logic [2:0]  cnt;
    logic        hv;
    logic        last;
  } vertex_out_t;

  // predictor of the clipped polygon and weights, plus the store of pending vertices
  class clip_scoreboard;
    longint      left, top, right, bottom;
    vertex_out_t pending_q[$];
    int          mismatches;
    longint      poly[MAX_VTX][2];
    int          npoly;
    bit          clipped;

    function new();
      left = 0; top = 0; right = CMAX; bottom = CMAX;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t r, coord_t v);
      case (r)
        REG_LEFT:   left = v;
        REG_TOP:    top = v;
        REG_RIGHT:  right = v;
        REG_BOTTOM: bottom = v;
      endcase
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // one clip pass along axis ax against the bound
    function void clip_edge(int ax, longint bound, bit keep_gt);
      longint tmp[MAX_VTX][2];
      int nout, prev, cur, ox;
      longint pc, cc, den, num, d, other;
      bit pin, cin, negoff;
      logic [127:0] m;
      nout = 0;
      ox = 1 - ax;
      if (npoly <= 0) return;
      prev = npoly - 1;
      for (cur = 0; cur < npoly; cur++) begin
        pc = poly[prev][ax];
        cc = poly[cur][ax];
        pin = keep_gt ? pc >= bound : pc <= bound;
        cin = keep_gt ? cc >= bound : cc <= bound;
        if (pin != cin) begin
          den = cc - pc;
          num = bound - pc;
          d = poly[cur][ox] - poly[prev][ox];
          m = (128'(mag(d)) * 128'(mag(num)) + 128'(mag(den) / 2)) / 128'(mag(den));
          negoff = ((d < 0) != (num < 0)) != (den < 0);
          other = negoff ? poly[prev][ox] - longint'(m) : poly[prev][ox] + longint'(m);
          if (d == 0 || num == 0) other = poly[prev][ox];
          if (nout < MAX_VTX) begin
            tmp[nout][ax] = bound;
            tmp[nout][ox] = other;
            nout++;
          end
          clipped = 1;
        end
        if (cin && nout < MAX_VTX) begin
          tmp[nout][0] = poly[cur][0];
          tmp[nout][1] = poly[cur][1];
          nout++;
        end
        prev = cur;
      end
      for (int k = 0; k < nout; k++) begin
        poly[k][0] = tmp[k][0];
        poly[k][1] = tmp[k][1];
      end
      npoly = nout;
    endfunction

    // num / den in Q1.FB, rounded, saturated to [0,1]
    function logic [FB:0] weight(wide_t num, wide_t den);
      wide_t q, rem;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num <= 0) return '0;
      if (num >= den) return (FB+1)'(1) << FB;
      q = (num <<< FB) / den;
      rem = (num <<< FB) - q * den;
      if (2 * rem >= den) q = q + 1;
      return q[FB:0];
    endfunction

    // accepted triangle: work out every vertex it will produce
    function void note_triangle(coord_t c[6]);
      longint x0, y0, x1, y1, x2, y2, px, py;
      wide_t dd, w0, w1;
      logic [1:0] st;
      vertex_out_t r;
      x0 = c[0]; y0 = c[1]; x1 = c[2]; y1 = c[3]; x2 = c[4]; y2 = c[5];
      poly[0][0] = x0; poly[0][1] = y0;
      poly[1][0] = x1; poly[1][1] = y1;
      poly[2][0] = x2; poly[2][1] = y2;
      npoly = 3;
      clipped = 0;
      clip_edge(0, left, 1);
      clip_edge(0, right, 0);
      clip_edge(1, top, 1);
      clip_edge(1, bottom, 0);
      if (npoly == 0) begin
        r = '0;
        r.st = ST_ALL;
        r.last = 1'b1;
        pending_q.push_back(r);
        return;
      end
      dd = wide_t'(y1 - y2) * wide_t'(x0 - x2) + wide_t'(x2 - x1) * wide_t'(y0 - y2);
      st = (dd == 0) ? ST_DEGEN : (clipped ? ST_SOME : ST_NONE);
      for (int k = 0; k < npoly; k++) begin
        r = '0;
        if (st != ST_DEGEN) begin
          px = poly[k][0] - x2;
          py = poly[k][1] - y2;
          w0 = wide_t'(y1 - y2) * wide_t'(px) + wide_t'(x2 - x1) * wide_t'(py);
          w1 = wide_t'(y2 - y0) * wide_t'(px) + wide_t'(x0 - x2) * wide_t'(py);
          r.wf = weight(w0, dd);
          r.ws = weight(w1, dd);
        end
        r.x = coord_t'(poly[k][0]);
        r.y = coord_t'(poly[k][1]);
        r.st = st;
        r.cnt = 3'(npoly);
        r.hv = 1'b1;
        r.last = (k == npoly - 1);
        pending_q.push_back(r);
      end
    endfunction

    // compare one accepted vertex with the oldest pending one
    function void check_result(vertex_out_t act);
      vertex_out_t exp_v;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex x=%0h y=%0h last=%0b", act.x, act.y, act.last);
        return;
      end
      exp_v = pending_q.pop_front();
      if (act != exp_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp x=%0h y=%0h wf=%0h ws=%0h st=%0d n=%0d hv=%0b last=%0b",
                    " got x=%0h y=%0h wf=%0h ws=%0h st=%0d n=%0d hv=%0b last=%0b"},
                   exp_v.x, exp_v.y, exp_v.wf, exp_v.ws, exp_v.st, exp_v.cnt, exp_v.hv,
                   exp_v.last, act.x, act.y, act.wf, act.ws, act.st, act.cnt, act.hv,
                   act.last);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  coord_t      first_x, first_y, second_x, second_y, third_x, third_y;
  coord_t      out_x, out_y;
  logic [FB:0] weight_first, weight_second;
  logic [1:0]  clip_status;
  logic [2:0]  vertex_count;
  logic        has_vertex, is_last;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  coord_t      cfg_data;

  clip_scoreboard sb;
  int idle_phase;
  int triangles_sent;
  int hold_left;
  bit hold_done;

  triangle_rectangle_clipper u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .second_x(second_x),
    .second_y(second_y), .third_x(third_x), .third_y(third_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y),
    .weight_first(weight_first), .weight_second(weight_second),
    .clip_status(clip_status), .vertex_count(vertex_count),
    .has_vertex(has_vertex), .is_last(is_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #200ms;
    $display("triangle_rectangle_clipper verification failed");
    $finish;
  end

  // result side: random stalls and one long hold while requests keep coming
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && triangles_sent == 60) begin
      hold_done <= 1'b1;
      hold_left <= 1500;
      out_ready <= 1'b0;
    end else begin
      case (idle_phase)
        0: out_ready <= $urandom_range(99) >= 67;
        1: out_ready <= $urandom_range(99) >= 36;
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{out_x, out_y, weight_first, weight_second, clip_status,
                        vertex_count, has_vertex, is_last});
  end

  // offer one triangle request and wait for it to be taken
  task automatic send_triangle(coord_t c[6]);
    int pct;
    pct = (idle_phase == 0) ? 36 : (idle_phase == 1) ? 67 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_x <= c[0]; first_y <= c[1];
    second_x <= c[2]; second_y <= c[3];
    third_x <= c[4]; third_y <= c[5];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_triangle(c);
    triangles_sent++;
  endtask

  task automatic send_fixed(longint ax, longint ay, longint bx, longint by,
                            longint cx, longint cy);
    coord_t c[6];
    c = '{coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
          coord_t'(cx), coord_t'(cy)};
    send_triangle(c);
  endtask

  // wait until every pending vertex has come and the block has gone idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // cfg_valid stays high between back to back writes
  task automatic write_reg(cfg_reg_t r, longint v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= coord_t'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(r, coord_t'(v));
  endtask

  task automatic set_rect(longint l, longint t, longint r, longint b);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    cfg_valid <= 1'b0;
  endtask

  // coordinate near the span lo..hi, sometimes on the boundary, sometimes anywhere
  function automatic coord_t pick_coord(longint lo, longint hi);
    longint a, b, span;
    int sel;
    sel = $urandom_range(99);
    a = (lo < hi ? lo : hi) - 64'h80000;
    b = (lo < hi ? hi : lo) + 64'h80000;
    span = b - a;
    if (sel < 12) return coord_t'($urandom);
    if (sel < 20) return coord_t'(($urandom_range(1)) ? lo : hi);
    if (span >= 64'h7FFFFFFF) return coord_t'($urandom);
    a = a + $urandom_range(int'(span));
    if (a < CMIN) a = CMIN;
    if (a > CMAX) a = CMAX;
    return coord_t'(a);
  endfunction

  task automatic random_triangles(int count);
    coord_t c[6];
    int sel;
    repeat (count) begin
      if (triangles_sent >= 250) idle_phase = 2;
      else if (triangles_sent >= 130) idle_phase = 1;
      for (int k = 0; k < 6; k += 2) begin
        c[k] = pick_coord(sb.left, sb.right);
        c[k+1] = pick_coord(sb.top, sb.bottom);
      end
      sel = $urandom_range(99);
      // collinear or repeated corners give zero area
      if (sel < 4) begin
        c[4] = c[0]; c[5] = c[1];
      end else if (sel < 7) begin
        c[4] = c[2]; c[5] = c[3];
      end else if (sel < 9) begin
        c[3] = c[1]; c[5] = c[1];
      end
      send_triangle(c);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    first_x = '0; first_y = '0; second_x = '0;
    second_y = '0; third_x = '0; third_y = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LEFT;
    cfg_data = '0;
    idle_phase = 0;
    triangles_sent = 0;
    hold_left = 0;
    hold_done = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default rectangle from origin to the positive maximum
    send_fixed(10 << 16, 10 << 16, 100 << 16, 10 << 16, 10 << 16, 100 << 16);
    send_fixed(-(10 << 16), -(10 << 16), -(100 << 16), -(5 << 16), -(3 << 16),
               -(90 << 16));
    send_fixed(-(20 << 16), 5 << 16, 40 << 16, 10 << 16, 10 << 16, 60 << 16);
    send_fixed(1 << 16, 1 << 16, 2 << 16, 2 << 16, 3 << 16, 3 << 16);
    send_fixed(-5, -5, -5, -5, -5, -5);
    send_fixed(0, 0, 50 << 16, 0, 0, 50 << 16);
    send_fixed(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX);
    send_fixed(CMAX, CMAX, CMIN, CMAX, CMIN, CMIN);
    send_fixed(CMAX, 0, 0, CMAX, CMAX, CMAX);
    send_fixed(-1, 7, 3, -1, 5, 9);
    drain();

    // small square: corner cuts up to the seven vertex limit
    set_rect(-(10 << 16), -(10 << 16), 10 << 16, 10 << 16);
    send_fixed(-(12 << 16), -(30 << 16), 30 << 16, 8 << 16, -(30 << 16), 12 << 16);
    send_fixed(-(13 << 16), 0, 0, -(13 << 16), 13 << 16, 13 << 16);
    send_fixed(-(40 << 16), -(40 << 16), 40 << 16, -(40 << 16), 0, 40 << 16);
    send_fixed(-(12 << 16), 12 << 16, 12 << 16, 12 << 16, 0, -(14 << 16));
    send_fixed(-(10 << 16), -(10 << 16), 10 << 16, -(10 << 16), 10 << 16, 10 << 16);
    random_triangles(60);
    drain();

    // widest rectangle, full range coordinates
    set_rect(CMIN, CMIN, CMAX, CMAX);
    send_fixed(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX);
    random_triangles(60);
    drain();

    // inverted rectangle clips everything
    set_rect(5 << 16, 0, -(5 << 16), 20 << 16);
    random_triangles(15);
    drain();
    set_rect(0, 5 << 16, 20 << 16, -(5 << 16));
    random_triangles(15);
    drain();

    // rectangle one step wide
    set_rect(3, -7, 4, -6);
    random_triangles(30);
    drain();

    // random rectangles
    repeat (4) begin
      set_rect(-$urandom_range(32'h00800000), -$urandom_range(32'h00800000),
               $urandom_range(32'h00800000), $urandom_range(32'h00800000));
      random_triangles(40);
      drain();
    end

    // back to the reset rectangle
    set_rect(0, 0, CMAX, CMAX);
    random_triangles(20);
    drain();

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("triangle_rectangle_clipper verification clean");
    end else begin
      $display("triangle_rectangle_clipper verification failed");
    end
    $finish;
  end

endmodule
